### rtl/cfga_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfga_pkg
// Types and constants shared by the cell facet gradient accumulator.
// ----------------------------------------------------------------------------
package cfga_pkg;

   localparam int SUM_W           = 52;
   localparam int DIV_W           = 31;
   localparam int FRACTION_BITS_D = 16;
   localparam int QUEUE_DEPTH_D   = 2;

   typedef struct packed {
      logic signed [31:0] normal_x;
      logic signed [31:0] normal_y;
      logic signed [31:0] normal_z;
      logic signed [31:0] face_value;
      logic signed [31:0] cell_volume;
      logic               last_facet;
   } req_data_type;

   typedef struct packed {
      logic signed [31:0] grad_x;
      logic signed [31:0] grad_y;
      logic signed [31:0] grad_z;
      logic               saturated;
   } rsp_data_type;

   typedef struct packed {
      logic [SUM_W-1:0] sum_x;
      logic [SUM_W-1:0] sum_y;
      logic [SUM_W-1:0] sum_z;
      logic [DIV_W-1:0] divisor;
   } element_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_SETUP,
      B_DIVIDE,
      B_STORE,
      B_OUT
   } back_state_type;

endpackage

### rtl/cfga_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfga_front
// Accepts facets, forms the three products and accumulates the running sums.
// ----------------------------------------------------------------------------
module cfga_front import cfga_pkg::*; #(
   parameter int FRACTION_BITS = FRACTION_BITS_D
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_data_type req_data,
   input  logic [30:0]  min_volume,
   input  logic         q_full,
   output logic         q_push,
   output element_type  q_entry
);

   logic                    s1_valid_ff, s1_valid_in;
   logic                    s1_last_ff;
   logic signed [63:0]      prod_x_ff, prod_y_ff, prod_z_ff;
   logic [DIV_W-1:0]        div_ff, div_in;
   logic [SUM_W-1:0]        sum_x_ff, sum_y_ff, sum_z_ff;
   logic [SUM_W-1:0]        nx, ny, nz;
   logic [30:0]             floor_vol;
   logic                    advance;
   logic                    accept;

   assign advance     = !(s1_valid_ff && s1_last_ff && q_full);
   assign req_stall   = !advance;
   assign accept      = req_valid && advance;
   assign s1_valid_in = accept;

   always_comb begin
      floor_vol = (min_volume == 31'd0) ? 31'd1 : min_volume;
      if ($signed({req_data.cell_volume[31], req_data.cell_volume}) <
          $signed({2'b00, floor_vol})) begin
         div_in = floor_vol;
      end else begin
         div_in = req_data.cell_volume[30:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s1_valid_in;
      end
      if (accept) begin
         prod_x_ff  <= 64'(req_data.normal_x) * 64'(req_data.face_value);
         prod_y_ff  <= 64'(req_data.normal_y) * 64'(req_data.face_value);
         prod_z_ff  <= 64'(req_data.normal_z) * 64'(req_data.face_value);
         s1_last_ff <= req_data.last_facet;
         div_ff     <= div_in;
      end
   end

   always_comb begin
      nx = sum_x_ff + SUM_W'(prod_x_ff >>> FRACTION_BITS);
      ny = sum_y_ff + SUM_W'(prod_y_ff >>> FRACTION_BITS);
      nz = sum_z_ff + SUM_W'(prod_z_ff >>> FRACTION_BITS);
   end

   assign q_push          = s1_valid_ff && s1_last_ff && !q_full;
   assign q_entry.sum_x   = nx;
   assign q_entry.sum_y   = ny;
   assign q_entry.sum_z   = nz;
   assign q_entry.divisor = div_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_x_ff <= '0;
         sum_y_ff <= '0;
         sum_z_ff <= '0;
      end else if (s1_valid_ff && advance) begin
         if (s1_last_ff) begin
            sum_x_ff <= '0;
            sum_y_ff <= '0;
            sum_z_ff <= '0;
         end else begin
            sum_x_ff <= nx;
            sum_y_ff <= ny;
            sum_z_ff <= nz;
         end
      end
   end

endmodule

### rtl/cfga_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfga_queue
// Short queue of finished element sums between the front and back parts.
// ----------------------------------------------------------------------------
module cfga_queue import cfga_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_D
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  element_type  wr_entry,
   output logic         full,
   input  logic         pop,
   output logic         empty,
   output element_type  rd_entry
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   element_type       mem [QUEUE_DEPTH];
   logic [PW-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]     count_ff;

   assign full     = (count_ff == CW'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign rd_entry = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + CW'(push) - CW'(pop);
      end
   end

endmodule

### rtl/cfga_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfga_back
// Divides the three sums by the volume one bit per cycle and saturates.
// ----------------------------------------------------------------------------
module cfga_back import cfga_pkg::*; #(
   parameter int FRACTION_BITS = FRACTION_BITS_D
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         q_empty,
   input  element_type  q_entry,
   output logic         q_pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_data_type rsp_data
);

   localparam int DW = SUM_W + FRACTION_BITS;
   localparam int SW = $clog2(DW + 1);

   back_state_type     state_ff, state_in;
   element_type        elem_ff;
   logic [1:0]         axis_ff;
   logic [SW-1:0]      step_ff;
   logic [DW-1:0]      dvd_ff;
   logic [DIV_W-1:0]   rem_ff;
   logic               neg_ff;
   logic [31:0]        grad_ff [3];
   logic               sat_ff;
   logic               rsp_valid_ff;
   rsp_data_type       rsp_data_ff;

   logic               do_load, do_setup, do_step, do_store, do_emit;
   logic [SUM_W-1:0]   sel_sum, mag;
   logic [DIV_W:0]     rem2;
   logic               ge;
   logic [DW-1:0]      limit;
   logic               over;
   logic [31:0]        res32, signed_res;
   logic               out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE:   if (!q_empty) state_in = B_SETUP;
         B_SETUP:  state_in = B_DIVIDE;
         B_DIVIDE: if (step_ff == SW'(DW - 1)) state_in = B_STORE;
         B_STORE:  state_in = (axis_ff == 2'd2) ? B_OUT : B_SETUP;
         B_OUT:    if (out_free) state_in = B_IDLE;
         default:  state_in = B_IDLE;
      endcase
   end

   always_comb begin
      do_load  = 1'b0;
      do_setup = 1'b0;
      do_step  = 1'b0;
      do_store = 1'b0;
      do_emit  = 1'b0;
      unique case (state_ff)
         B_IDLE:   do_load  = !q_empty;
         B_SETUP:  do_setup = 1'b1;
         B_DIVIDE: do_step  = 1'b1;
         B_STORE:  do_store = 1'b1;
         B_OUT:    do_emit  = out_free;
         default:  ;
      endcase
   end

   assign q_pop = do_load;

   always_comb begin
      unique case (axis_ff)
         2'd0:    sel_sum = elem_ff.sum_x;
         2'd1:    sel_sum = elem_ff.sum_y;
         default: sel_sum = elem_ff.sum_z;
      endcase
      mag  = sel_sum[SUM_W-1] ? (~sel_sum + 1'b1) : sel_sum;
      rem2 = {rem_ff, dvd_ff[DW-1]};
      ge   = (rem2 >= {1'b0, elem_ff.divisor});
      limit = neg_ff ? DW'(33'h080000000) : DW'(33'h07FFFFFFF);
      over  = (dvd_ff > limit);
      res32 = over ? limit[31:0] : dvd_ff[31:0];
      signed_res = neg_ff ? (~res32 + 1'b1) : res32;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (do_emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_load) begin
         elem_ff <= q_entry;
         axis_ff <= 2'd0;
         sat_ff  <= 1'b0;
      end
      if (do_setup) begin
         neg_ff  <= sel_sum[SUM_W-1];
         dvd_ff  <= {mag, FRACTION_BITS'(0)};
         rem_ff  <= '0;
         step_ff <= '0;
      end
      if (do_step) begin
         rem_ff  <= ge ? DIV_W'(rem2 - {1'b0, elem_ff.divisor}) : rem2[DIV_W-1:0];
         dvd_ff  <= {dvd_ff[DW-2:0], ge};
         step_ff <= step_ff + 1'b1;
      end
      if (do_store) begin
         grad_ff[axis_ff] <= signed_res;
         sat_ff           <= sat_ff | over;
         axis_ff          <= axis_ff + 1'b1;
      end
      if (do_emit) begin
         rsp_data_ff.grad_x    <= grad_ff[0];
         rsp_data_ff.grad_y    <= grad_ff[1];
         rsp_data_ff.grad_z    <= grad_ff[2];
         rsp_data_ff.saturated <= sat_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### rtl/cell_face_gradient_accumulator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cell_face_gradient_accumulator_top
// Green-Gauss gradient of a field at an element center from its facets.
// ----------------------------------------------------------------------------
// Facets arrive on the req_ channel, one item per facet, and an item is
// accepted when req_valid is high and req_stall is low. The front end takes
// one facet per cycle while req_stall is low: a registered 32x32 multiply
// per axis, then a 52-bit accumulate. The facet marked last_facet closes the
// element; its sums and clamped volume enter a short queue. The back end
// divides the three sums one quotient bit per cycle, after a setup state per
// axis, and presents the result on the rsp_ channel. That divider sets the
// element rate; facets of later elements keep flowing until the queue fills,
// and req_stall rises only while a last facet waits for a queue slot. A
// stalled result stays in the output register. Synchronous reset clears
// the sums, the queue and the handshake state, and sets min_volume to one.
// csr_ writes load min_volume.
// ----------------------------------------------------------------------------
module cell_face_gradient_accumulator_top import cfga_pkg::*; #(
   parameter int FRACTION_BITS = FRACTION_BITS_D,
   parameter int QUEUE_DEPTH   = QUEUE_DEPTH_D
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_data_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_data_type rsp_data,
   input  logic         csr_write,
   input  logic [30:0]  csr_wdata
);

   logic [30:0]   min_volume_ff;
   logic          q_push, q_full, q_pop, q_empty;
   element_type   wr_entry, rd_entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_volume_ff <= 31'd1;
      end else if (csr_write) begin
         min_volume_ff <= csr_wdata;
      end
   end

   cfga_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .min_volume (min_volume_ff),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (wr_entry)
   );

   cfga_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .wr_entry (wr_entry),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .rd_entry (rd_entry)
   );

   cfga_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_entry   (rd_entry),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

### rtl/cfga_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfga_checker
// Port-level checks on the result channel of the gradient accumulator.
// ----------------------------------------------------------------------------
module cfga_checker import cfga_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_data_type rsp_data
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown(rsp_data))
      else $error("result item has unknown bits");

   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.saturated |->
         (rsp_data.grad_x == 32'sh7FFFFFFF || rsp_data.grad_x == 32'sh80000000 ||
          rsp_data.grad_y == 32'sh7FFFFFFF || rsp_data.grad_y == 32'sh80000000 ||
          rsp_data.grad_z == 32'sh7FFFFFFF || rsp_data.grad_z == 32'sh80000000))
      else $error("saturation flag without a clipped component");

endmodule

bind cell_face_gradient_accumulator_top cfga_checker u_cfga_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

### tb/cell_face_gradient_accumulator_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cell_face_gradient_accumulator_top_test
// Self-checking test of the facet gradient accumulator.
// ----------------------------------------------------------------------------
// Elements of facets are streamed into the block while a predictor inside
// the testbench keeps its own running sums and divides them on each last
// facet. Every gradient that comes out is checked against the oldest
// predicted one. The run walks through several min_volume settings, with
// random gaps on both channels and a long output hold.
// ----------------------------------------------------------------------------
module cell_face_gradient_accumulator_top_test;
   import cfga_pkg::*;

   localparam int FRAC        = FRACTION_BITS_D;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int HOLD_CYCLES = 800;
   localparam int SETTLE      = 300;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_data_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_data_type rsp_data;
   logic         csr_write;
   logic [30:0]  csr_wdata;

   req_data_type facet_queue[$];
   rsp_data_type gradient_queue[$];
   logic [51:0]  acc_x, acc_y, acc_z;
   logic [30:0]  min_volume;
   int           facets_queued;
   int           facets_taken;
   int           errors;
   int           cycles;
   int           send_gap;
   int           recv_gap;
   int           hold_left;
   bit           hold_taken;
   logic         hold_request;
   logic         quiet;

   cell_face_gradient_accumulator_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [51:0] facet_product(logic signed [31:0] n,
                                                 logic signed [31:0] f);
      longint signed p;
      p = longint'(n) * longint'(f);
      p = p >>> FRAC;
      return p[51:0];
   endfunction

   function automatic logic [31:0] scaled_quotient(logic [51:0] sum,
                                                   longint unsigned divisor,
                                                   inout bit sat);
      longint signed   s;
      bit              neg;
      longint unsigned mag, q, r, lim, res;
      s   = longint'(signed'(sum));
      neg = s < 0;
      mag = neg ? longint'(-s) : longint'(s);
      q   = mag / divisor;
      r   = mag % divisor;
      lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
      if (q >= (64'd1 << 39)) begin
         res = lim + 1;
      end else begin
         res = (q << FRAC) + ((r << FRAC) / divisor);
      end
      if (res > lim) begin
         res = lim;
         sat = 1'b1;
      end
      if (neg) begin
         res = -res;
      end
      return res[31:0];
   endfunction

   task automatic predict_facet(req_data_type f);
      longint signed floor_vol;
      longint signed vol;
      bit            sat;
      rsp_data_type  g;
      sat = 1'b0;
      acc_x = acc_x + facet_product(f.normal_x, f.face_value);
      acc_y = acc_y + facet_product(f.normal_y, f.face_value);
      acc_z = acc_z + facet_product(f.normal_z, f.face_value);
      if (f.last_facet) begin
         floor_vol = (min_volume == 0) ? 1 : longint'(min_volume);
         vol = longint'(f.cell_volume);
         if (vol < floor_vol) begin
            vol = floor_vol;
         end
         g.grad_x    = scaled_quotient(acc_x, vol, sat);
         g.grad_y    = scaled_quotient(acc_y, vol, sat);
         g.grad_z    = scaled_quotient(acc_z, vol, sat);
         g.saturated = sat;
         gradient_queue.push_back(g);
         acc_x = '0;
         acc_y = '0;
         acc_z = '0;
      end
   endtask

   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      $display("mismatch in %s: got %h, expected %h", field, got, want);
      errors++;
   endtask

   // Sender: one item in flight, held while stalled.
   always @(posedge clock) begin
      req_data_type next_data;
      logic         next_valid;
      bit           taken;
      next_data  = req_data;
      next_valid = req_valid;
      taken      = 1'b0;
      if (reset) begin
         next_valid = 1'b0;
         send_gap   = 0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_facet(req_data);
            facets_taken++;
            taken = 1'b1;
         end
         if (!req_valid || taken) begin
            next_valid = 1'b0;
            if (send_gap > 0) begin
               send_gap--;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
               send_gap = $urandom_range(0, 3);
            end else if (facet_queue.size() > 0) begin
               next_data  = facet_queue.pop_front();
               next_valid = 1'b1;
            end
         end
      end
      req_valid <= next_valid;
      req_data  <= next_data;
   end

   // Receiver: random stall bursts plus one long hold on request.
   always @(posedge clock) begin
      logic next_stall;
      next_stall = 1'b0;
      if (reset) begin
         recv_gap   = 0;
         hold_left  = 0;
         hold_taken = 1'b0;
      end else if (hold_request && !hold_taken) begin
         hold_taken = 1'b1;
         hold_left  = HOLD_CYCLES;
         next_stall = 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         next_stall = 1'b1;
      end else if (recv_gap > 0) begin
         recv_gap--;
         next_stall = 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         recv_gap   = $urandom_range(0, 3);
         next_stall = 1'b1;
      end
      rsp_stall <= next_stall;
   end

   always @(posedge clock) begin
      rsp_data_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (gradient_queue.size() == 0) begin
            report_mismatch("unexpected item", rsp_data.grad_x, 32'h0);
         end else begin
            want = gradient_queue.pop_front();
            if (rsp_data.grad_x !== want.grad_x)
               report_mismatch("grad_x", rsp_data.grad_x, want.grad_x);
            if (rsp_data.grad_y !== want.grad_y)
               report_mismatch("grad_y", rsp_data.grad_y, want.grad_y);
            if (rsp_data.grad_z !== want.grad_z)
               report_mismatch("grad_z", rsp_data.grad_z, want.grad_z);
            if (rsp_data.saturated !== want.saturated)
               report_mismatch("saturated", 32'(rsp_data.saturated),
                               32'(want.saturated));
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("cell_face_gradient_accumulator_top_test: FAIL");
         $finish;
      end
   end

   function automatic logic [31:0] pick_word(int style);
      case (style)
         0: return $urandom;
         1: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
         default: return $urandom_range(0, 32'h0000_4000) - 32'h0000_2000;
      endcase
   endfunction

   function automatic logic [31:0] pick_volume(int style);
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return -$urandom_range(0, 32'h0100_0000);
         2: return 32'h0;
         3: return $urandom_range(1, 32'h0001_0000);
         default: return (style == 0) ? $urandom : $urandom_range(32'h400, 32'h0400_0000);
      endcase
   endfunction

   task automatic queue_facet(logic [31:0] nx, logic [31:0] ny, logic [31:0] nz,
                              logic [31:0] fv, logic [31:0] vol, logic last);
      req_data_type f;
      f.normal_x    = nx;
      f.normal_y    = ny;
      f.normal_z    = nz;
      f.face_value  = fv;
      f.cell_volume = vol;
      f.last_facet  = last;
      facet_queue.push_back(f);
      facets_queued++;
   endtask

   task automatic queue_element(int facets, int style);
      for (int i = 0; i < facets; i++) begin
         queue_facet(pick_word(style), pick_word(style), pick_word(style),
                     pick_word(style), pick_volume(style), i == facets - 1);
      end
   endtask

   task automatic queue_random(int count);
      int n;
      n = 0;
      while (n < count) begin
         int k;
         int style;
         k = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
         style = $urandom_range(0, 3);
         if (style == 3) begin
            style = 1;
         end
         queue_element(k, style);
         n += k;
      end
   endtask

   task automatic drain;
      while (facets_taken != facets_queued || gradient_queue.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_min_volume(logic [30:0] v);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_write <= 1'b0;
      min_volume = v;
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      rsp_stall     = 1'b0;
      csr_write     = 1'b0;
      csr_wdata     = '0;
      hold_request  = 1'b0;
      quiet         = 1'b0;
      acc_x         = '0;
      acc_y         = '0;
      acc_z         = '0;
      min_volume    = 31'd1;
      facets_queued = 0;
      facets_taken  = 0;
      errors        = 0;
      cycles        = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      queue_facet(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h0000_0001, 1'b1);
      queue_facet(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 1'b1);
      queue_facet(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001,
                  32'h8000_0000, 1'b1);
      queue_facet(32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000, 32'h0003_0000,
                  32'h0000_0000, 1'b0);
      queue_facet(32'h0001_0000, 32'h0001_0000, 32'hFFFE_0000, 32'h0001_8000,
                  32'hFFFF_0000, 1'b1);
      queue_facet(32'h0010_0000, 32'h0020_0000, 32'hFFF0_0000, 32'h0004_0000,
                  32'h0008_0000, 1'b1);
      for (int i = 0; i < 16; i++) begin
         queue_facet(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                     32'h7FFF_FFFF, i == 15);
      end
      drain();

      set_min_volume(31'd0);
      queue_facet(32'h0003_0000, 32'hFFFD_0000, 32'h0000_0001, 32'h0001_0000,
                  32'hFFFF_FFFF, 1'b1);
      queue_random(250);
      drain();

      set_min_volume(31'h7FFF_FFFF);
      queue_random(250);
      drain();

      set_min_volume(31'h0001_0000);
      hold_request <= 1'b1;
      for (int i = 0; i < 60; i++) begin
         queue_element($urandom_range(1, 3), 2);
      end
      queue_random(350);
      drain();

      set_min_volume(31'($urandom_range(1, 32'h0100_0000)));
      queue_random(500);
      drain();

      set_min_volume(31'd1);
      quiet <= 1'b1;
      queue_random(450);
      drain();

      if (errors == 0) begin
         $display("cell_face_gradient_accumulator_top_test: PASS");
      end else begin
         $display("cell_face_gradient_accumulator_top_test: FAIL");
      end
      $finish;
   end

endmodule
